### src/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants for the I2C register master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crm_pkg;

  localparam int READ_BYTES  = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_READ_START_REGISTER = 1'd1;

  localparam logic [6:0] DEVICE_ADDRESS_RST      = 7'd28;
  localparam logic [7:0] READ_START_REGISTER_RST = 8'h01;

  localparam logic [4:0] LAST_BYTE_INDEX = 5'(READ_BYTES - 1);

  typedef struct packed {
    logic       cmd_valid;
    logic       operation;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] read_start_register;
  } cfg_t;

endpackage

`default_nettype wire

### src/i2crm_if.sv
// ----------------------------------------------------------------------------
// i2crm_in_if / i2crm_out_if
// Valid/ready channels for ticks in and per-tick results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2crm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic       operation;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, cmd_valid, operation, reg_addr, write_data, sda_in,
                  input ready);
  modport sink   (input valid, cmd_valid, operation, reg_addr, write_data, sda_in,
                  output ready);
endinterface

interface i2crm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [4:0] read_index;
  logic       last_byte;
  logic       slave_ack;
  logic       done_res;

  modport source (output valid, scl_out, sda_out, busy_res, read_valid, read_byte,
                         read_index, last_byte, slave_ack, done_res,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, read_valid, read_byte,
                        read_index, last_byte, slave_ack, done_res,
                  output ready);
endinterface

`default_nettype wire

### src/i2c_register_master.sv
// ----------------------------------------------------------------------------
// i2c_register_master
// Tick-driven I2C master for register writes and burst reads.
//
//   channel  dir  beat
//   in_ch    in   one half-bit tick: command fields and sampled SDA
//   out_ch   out  SCL/SDA levels, busy, read byte, slave ack, done
//   cfg_*    in   register write: index, data
//
// One beat per cycle unless out_ch stalls; the sequencer steps once per beat.
// A result passes through the input register, the two-entry queue and the
// output register before it leaves.
// Synchronous reset returns the sequencer to idle; the line registers are not reset.
// A stalled out_ch fills the queue, then drops in_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_master (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  i2crm_in_if.sink                              in_ch,
  i2crm_out_if.source                           out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [i2crm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [i2crm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2crm_pkg::*;

  cfg_t     cfg_r;
  in_item_t f_item, q_item;
  logic     f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address      <= DEVICE_ADDRESS_RST;
      cfg_r.read_start_register <= READ_START_REGISTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS:      cfg_r.device_address      <= cfg_data[6:0];
        CFG_READ_START_REGISTER: cfg_r.read_start_register <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  i2crm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  i2crm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_item  (f_item),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  i2crm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### src/i2crm_front.sv
// ----------------------------------------------------------------------------
// i2crm_front
// Input stage: takes a beat, packs and holds it until the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crm_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  i2crm_in_if.sink           in_ch,
  output i2crm_pkg::in_item_t item,
  output logic               item_valid,
  input  wire logic          item_ready
);
  import i2crm_pkg::*;

  logic     valid_r;
  in_item_t item_r;
  logic     take;

  assign in_ch.ready = !valid_r || item_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign item        = item_r;
  assign item_valid  = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (item_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.cmd_valid  <= in_ch.cmd_valid;
      item_r.operation  <= in_ch.operation;
      item_r.reg_addr   <= in_ch.reg_addr;
      item_r.write_data <= in_ch.write_data;
      item_r.sda_in     <= in_ch.sda_in;
    end
  end

endmodule

`default_nettype wire

### src/i2crm_queue.sv
// ----------------------------------------------------------------------------
// i2crm_queue
// Short FIFO between the input stage and the bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  i2crm_pkg::in_item_t wr_item,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  output i2crm_pkg::in_item_t rd_item,
  output logic                rd_valid,
  input  wire logic           rd_ready
);
  import i2crm_pkg::*;

  in_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  logic              pop;

  assign wr_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

### src/i2crm_seq.sv
// ----------------------------------------------------------------------------
// i2crm_seq
// Bus sequencer: one half-bit tick per beat, result held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crm_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  i2crm_pkg::cfg_t     cfg,
  input  i2crm_pkg::in_item_t item,
  input  wire logic           item_valid,
  output logic                item_ready,
  i2crm_out_if.source         out_ch
);
  import i2crm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_WADDR, PH_REG, PH_DATA,
    PH_RS_A, PH_RS_B, PH_RS_C, PH_RADDR, PH_RX, PH_SP_A, PH_SP_B, PH_SP_C
  } phase_t;

  phase_t     phase_r,    phase_nxt;
  logic [3:0] bit_cnt_r,  bit_cnt_nxt;
  logic [4:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0] shift_r,    shift_nxt;
  logic [7:0] held_reg_r, held_reg_nxt;
  logic [7:0] held_dat_r, held_dat_nxt;
  logic       held_op_r,  held_op_nxt;
  logic       ack_r,      ack_nxt;
  logic       half_r,     half_nxt;

  logic       out_valid_r;
  logic       scl_r, sda_r, busy_r, rvalid_r, rlast_r, done_r;
  logic [7:0] rbyte_r;
  logic [4:0] ridx_r;

  logic       scl, sda, busy, rvalid, rlast, done;
  logic [7:0] rbyte;
  logic [4:0] ridx;
  logic       fire;

  assign item_ready = !out_valid_r || out_ch.ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    phase_t ph;
    logic   is_ack;
    logic   is_last;
    ph           = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    held_reg_nxt = held_reg_r;
    held_dat_nxt = held_dat_r;
    held_op_nxt  = held_op_r;
    ack_nxt      = ack_r;
    half_nxt     = half_r;
    scl    = 1'b1;
    sda    = 1'b1;
    busy   = 1'b1;
    rvalid = 1'b0;
    rbyte  = '0;
    ridx   = '0;
    rlast  = 1'b0;
    done   = 1'b0;

    if (phase_r == PH_IDLE && item.cmd_valid) begin
      held_op_nxt  = item.operation;
      held_reg_nxt = item.operation ? cfg.read_start_register : item.reg_addr;
      held_dat_nxt = item.write_data;
      byte_cnt_nxt = '0;
      bit_cnt_nxt  = '0;
      half_nxt     = 1'b0;
      ph           = PH_ST_A;
    end

    is_ack    = bit_cnt_nxt[3];
    is_last   = byte_cnt_nxt >= LAST_BYTE_INDEX;
    phase_nxt = ph;

    unique case (ph)
      PH_ST_A: begin phase_nxt = PH_ST_B; end
      PH_RS_A: begin phase_nxt = PH_RS_B; end
      PH_ST_B: begin sda = 1'b0; phase_nxt = PH_ST_C; end
      PH_RS_B: begin sda = 1'b0; phase_nxt = PH_RS_C; end
      PH_ST_C, PH_RS_C: begin
        scl         = 1'b0;
        sda         = 1'b0;
        phase_nxt   = (ph == PH_ST_C) ? PH_WADDR : PH_RADDR;
        shift_nxt   = {cfg.device_address, ph == PH_RS_C};
        bit_cnt_nxt = '0;
        half_nxt    = 1'b0;
      end
      PH_WADDR, PH_REG, PH_DATA, PH_RADDR: begin
        sda = is_ack ? 1'b1 : shift_r[~bit_cnt_r[2:0]];
        scl = !half_r;
        if (!half_r) begin
          if (is_ack) begin
            ack_nxt = item.sda_in;
          end
          half_nxt = 1'b1;
        end else if (!is_ack) begin
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          half_nxt    = 1'b0;
        end else begin
          bit_cnt_nxt = '0;
          half_nxt    = 1'b0;
          unique case (ph)
            PH_WADDR: begin phase_nxt = PH_REG; shift_nxt = held_reg_r; end
            PH_REG: begin
              if (held_op_r) begin
                phase_nxt = PH_RS_A;
              end else begin
                phase_nxt = PH_DATA;
                shift_nxt = held_dat_r;
              end
            end
            PH_DATA: begin phase_nxt = PH_SP_A; end
            default: begin
              phase_nxt    = PH_RX;
              shift_nxt    = '0;
              byte_cnt_nxt = '0;
            end
          endcase
        end
      end
      PH_RX: begin
        sda = is_ack ? is_last : 1'b1;
        scl = !half_r;
        if (!half_r) begin
          if (!is_ack) begin
            shift_nxt = {shift_r[6:0], item.sda_in};
            if (bit_cnt_r == 4'd7) begin
              rvalid = 1'b1;
              rbyte  = shift_nxt;
              ridx   = byte_cnt_r;
              rlast  = is_last;
            end
          end
          half_nxt = 1'b1;
        end else if (!is_ack) begin
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          half_nxt    = 1'b0;
        end else begin
          bit_cnt_nxt = '0;
          half_nxt    = 1'b0;
          if (is_last) begin
            phase_nxt = PH_SP_A;
          end else begin
            byte_cnt_nxt = byte_cnt_r + 1'b1;
            shift_nxt    = '0;
          end
        end
      end
      PH_SP_A: begin scl = 1'b0; sda = 1'b0; phase_nxt = PH_SP_B; end
      PH_SP_B: begin sda = 1'b0; phase_nxt = PH_SP_C; end
      PH_SP_C: begin done = 1'b1; phase_nxt = PH_IDLE; end
      default: begin busy = 1'b0; phase_nxt = PH_IDLE; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      shift_r     <= '0;
      held_reg_r  <= '0;
      held_dat_r  <= '0;
      held_op_r   <= 1'b0;
      ack_r       <= 1'b1;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      shift_r     <= shift_nxt;
      held_reg_r  <= held_reg_nxt;
      held_dat_r  <= held_dat_nxt;
      held_op_r   <= held_op_nxt;
      ack_r       <= ack_nxt;
      half_r      <= half_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      scl_r    <= scl;
      sda_r    <= sda;
      busy_r   <= busy;
      rvalid_r <= rvalid;
      rbyte_r  <= rbyte;
      ridx_r   <= ridx;
      rlast_r  <= rlast;
      done_r   <= done;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_out    = scl_r;
  assign out_ch.sda_out    = sda_r;
  assign out_ch.busy_res   = busy_r;
  assign out_ch.read_valid = rvalid_r;
  assign out_ch.read_byte  = rbyte_r;
  assign out_ch.read_index = ridx_r;
  assign out_ch.last_byte  = rlast_r;
  assign out_ch.slave_ack  = ack_r;
  assign out_ch.done_res   = done_r;

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for the tick-driven I2C register master. Each input beat is one
// half-bit tick; a behavioural sequencer in the bench predicts the bus levels,
// busy/done flags, read bytes and slave ack for every tick, and every output
// beat is checked field by field against the oldest prediction. Directed
// transfers cover the field extremes, both operations, commands while busy,
// slave NACK, configuration changes mid-transfer and a long output stall;
// a random phase follows with random bursts of idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import i2crm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RANDOM_TICKS = 200;
  localparam int  CALM_TICKS   = 60;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_READ     = 1'b1;

  typedef enum logic [4:0] {
    BUS_IDLE, START_A, START_B, START_C, WR_ADDR, REG_BYTE, DATA_BYTE,
    RSTART_A, RSTART_B, RSTART_C, RD_ADDR, RX_BYTE, STOP_A, STOP_B, STOP_C
  } bus_phase_t;

  typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       rvalid;
    logic [7:0] rbyte;
    logic [4:0] ridx;
    logic       rlast;
    logic       ack;
    logic       done;
  } bus_tick_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  i2crm_in_if  in_ch ();
  i2crm_out_if out_ch ();

  i2c_register_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sequencer copy
  logic [6:0] dev_addr     = DEVICE_ADDRESS_RST;
  logic [7:0] rd_start_reg = READ_START_REGISTER_RST;
  bus_phase_t bus_phase    = BUS_IDLE;
  logic [3:0] bit_cnt      = '0;
  logic [4:0] byte_cnt     = '0;
  logic [7:0] shreg        = '0;
  logic [7:0] latched_reg  = '0;
  logic [7:0] latched_data = '0;
  logic       latched_op   = 1'b0;
  logic       ack_bit      = 1'b1;
  logic       half_low     = 1'b0;

  bus_tick_t expected_ticks[$];
  int  failures = 0;
  int  cycles   = 0;
  int  hold_off = 0;
  bit  calm     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void load_byte(bus_phase_t ph, logic [7:0] value);
    bus_phase = ph;
    shreg     = value;
    bit_cnt   = '0;
    half_low  = 1'b0;
  endfunction

  function automatic bus_tick_t predict_bus_tick(in_item_t t);
    bus_tick_t r;
    logic is_ack;
    logic is_last;
    r      = '0;
    r.scl  = 1'b1;
    r.sda  = 1'b1;
    r.busy = 1'b1;
    if (bus_phase == BUS_IDLE && t.cmd_valid) begin
      latched_op   = t.operation;
      latched_reg  = (t.operation == OP_READ) ? rd_start_reg : t.reg_addr;
      latched_data = t.write_data;
      byte_cnt     = '0;
      bit_cnt      = '0;
      half_low     = 1'b0;
      bus_phase    = START_A;
    end
    case (bus_phase)
      START_A:  bus_phase = START_B;
      RSTART_A: bus_phase = RSTART_B;
      START_B: begin
        r.sda = 1'b0;
        bus_phase = START_C;
      end
      RSTART_B: begin
        r.sda = 1'b0;
        bus_phase = RSTART_C;
      end
      START_C: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
        load_byte(WR_ADDR, {dev_addr, 1'b0});
      end
      RSTART_C: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
        load_byte(RD_ADDR, {dev_addr, 1'b1});
      end
      WR_ADDR, REG_BYTE, DATA_BYTE, RD_ADDR: begin
        is_ack = (bit_cnt >= 4'd8);
        r.sda  = is_ack ? 1'b1 : shreg[~bit_cnt[2:0]];
        r.scl  = ~half_low;
        if (!half_low) begin
          if (is_ack) ack_bit = t.sda_in;
          half_low = 1'b1;
        end else if (!is_ack) begin
          bit_cnt  = bit_cnt + 4'd1;
          half_low = 1'b0;
        end else if (bus_phase == WR_ADDR) begin
          load_byte(REG_BYTE, latched_reg);
        end else if (bus_phase == REG_BYTE) begin
          if (latched_op == OP_READ) begin
            bus_phase = RSTART_A;
            half_low  = 1'b0;
            bit_cnt   = '0;
          end else begin
            load_byte(DATA_BYTE, latched_data);
          end
        end else if (bus_phase == DATA_BYTE) begin
          bus_phase = STOP_A;
          half_low  = 1'b0;
          bit_cnt   = '0;
        end else begin
          byte_cnt = '0;
          load_byte(RX_BYTE, 8'h00);
        end
      end
      RX_BYTE: begin
        is_last = (int'(byte_cnt) + 1) >= READ_BYTES;
        is_ack  = (bit_cnt >= 4'd8);
        r.sda   = is_ack ? is_last : 1'b1;
        r.scl   = ~half_low;
        if (!half_low) begin
          if (!is_ack) begin
            shreg = {shreg[6:0], t.sda_in};
            if (bit_cnt == 4'd7) begin
              r.rvalid = 1'b1;
              r.rbyte  = shreg;
              r.ridx   = byte_cnt;
              r.rlast  = is_last;
            end
          end
          half_low = 1'b1;
        end else if (!is_ack) begin
          bit_cnt  = bit_cnt + 4'd1;
          half_low = 1'b0;
        end else if (is_last) begin
          bus_phase = STOP_A;
          half_low  = 1'b0;
          bit_cnt   = '0;
        end else begin
          byte_cnt = byte_cnt + 5'd1;
          load_byte(RX_BYTE, 8'h00);
        end
      end
      STOP_A: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
        bus_phase = STOP_B;
      end
      STOP_B: begin
        r.sda = 1'b0;
        bus_phase = STOP_C;
      end
      STOP_C: begin
        r.done = 1'b1;
        bus_phase = BUS_IDLE;
      end
      default: begin
        bus_phase = BUS_IDLE;
        r.busy = 1'b0;
      end
    endcase
    r.ack = ack_bit;
    return r;
  endfunction

  // output side: random stalls, plus a long hold-off when asked
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off = hold_off - 1;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall = stall - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall = $urandom_range(0, 7);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    bus_tick_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t: output beat with nothing expected, expected none, actual scl %0b sda %0b",
                 $time, out_ch.scl_out, out_ch.sda_out);
        failures++;
      end else begin
        exp = expected_ticks.pop_front();
        check_field("scl_out",    8'(exp.scl),    8'(out_ch.scl_out));
        check_field("sda_out",    8'(exp.sda),    8'(out_ch.sda_out));
        check_field("busy_res",   8'(exp.busy),   8'(out_ch.busy_res));
        check_field("read_valid", 8'(exp.rvalid), 8'(out_ch.read_valid));
        check_field("read_byte",  exp.rbyte,      out_ch.read_byte);
        check_field("read_index", 8'(exp.ridx),   8'(out_ch.read_index));
        check_field("last_byte",  8'(exp.rlast),  8'(out_ch.last_byte));
        check_field("slave_ack",  8'(exp.ack),    8'(out_ch.slave_ack));
        check_field("done_res",   8'(exp.done),   8'(out_ch.done_res));
      end
    end
  end

  task automatic send_tick(input in_item_t t);
    in_ch.valid      <= 1'b1;
    in_ch.cmd_valid  <= t.cmd_valid;
    in_ch.operation  <= t.operation;
    in_ch.reg_addr   <= t.reg_addr;
    in_ch.write_data <= t.write_data;
    in_ch.sda_in     <= t.sda_in;
    do @(posedge clk); while (!in_ch.ready);
    expected_ticks.push_back(predict_bus_tick(t));
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_DEVICE_ADDRESS) dev_addr = value[6:0];
    else rd_start_reg = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic bus_tick(input logic chatter, input sda_mode_t mode);
    in_item_t t;
    t.cmd_valid  = chatter ? 1'($urandom) : 1'b0;
    t.operation  = 1'($urandom);
    t.reg_addr   = 8'($urandom);
    t.write_data = 8'($urandom);
    t.sda_in     = (mode == SDA_RANDOM) ? 1'($urandom) : (mode == SDA_HIGH);
    send_tick(t);
  endtask

  // starts from an idle bus and runs until the stop completes
  task automatic run_transfer(input logic op, input logic [7:0] reg_a, input logic [7:0] data,
                              input sda_mode_t mode, input logic chatter);
    in_item_t t;
    t.cmd_valid  = 1'b1;
    t.operation  = op;
    t.reg_addr   = reg_a;
    t.write_data = data;
    t.sda_in     = (mode == SDA_RANDOM) ? 1'($urandom) : (mode == SDA_HIGH);
    send_tick(t);
    while (bus_phase != BUS_IDLE) bus_tick(chatter, mode);
  endtask

  task automatic run_transfer_start(input logic op);
    in_item_t t;
    t.cmd_valid  = 1'b1;
    t.operation  = op;
    t.reg_addr   = 8'($urandom);
    t.write_data = 8'($urandom);
    t.sda_in     = 1'($urandom);
    send_tick(t);
  endtask

  task automatic test_idle_bus();
    repeat (4) bus_tick(1'b0, SDA_RANDOM);
  endtask

  task automatic test_write_extremes();
    run_transfer(OP_WRITE, 8'hFF, 8'h00, SDA_LOW, 1'b0);
    run_transfer(OP_WRITE, 8'h00, 8'hFF, SDA_HIGH, 1'b0);
  endtask

  task automatic test_read_extremes();
    run_transfer(OP_READ, 8'h00, 8'h00, SDA_HIGH, 1'b0);
    run_transfer(OP_READ, 8'hFF, 8'hFF, SDA_LOW, 1'b0);
  endtask

  task automatic test_cmd_while_busy();
    run_transfer(OP_WRITE, 8'($urandom), 8'($urandom), SDA_RANDOM, 1'b1);
    run_transfer(OP_READ, 8'($urandom), 8'($urandom), SDA_RANDOM, 1'b1);
  endtask

  task automatic test_cfg_settings();
    logic [7:0] dev_vals[2];
    logic [7:0] rs_vals[2];
    dev_vals = '{8'h00, 8'hFF};
    rs_vals  = '{8'hFF, 8'h00};
    for (int i = 0; i < 2; i++) begin
      drain_pipeline();
      write_cfg(CFG_DEVICE_ADDRESS, dev_vals[i]);
      write_cfg(CFG_READ_START_REGISTER, rs_vals[i]);
      run_transfer(OP_READ, 8'($urandom), 8'($urandom), SDA_RANDOM, 1'b0);
    end
  endtask

  task automatic test_cfg_mid_transfer();
    // address change just before the write address goes out
    drain_pipeline();
    run_transfer_start(OP_WRITE);
    drain_pipeline();
    write_cfg(CFG_DEVICE_ADDRESS, 8'($urandom));
    while (bus_phase != BUS_IDLE) bus_tick(1'b0, SDA_RANDOM);
    // change between the write and read address bytes of a burst
    run_transfer_start(OP_READ);
    while (bus_phase != REG_BYTE) bus_tick(1'b0, SDA_RANDOM);
    drain_pipeline();
    write_cfg(CFG_DEVICE_ADDRESS, 8'($urandom));
    write_cfg(CFG_READ_START_REGISTER, 8'($urandom));
    while (bus_phase != BUS_IDLE) bus_tick(1'b0, SDA_RANDOM);
  endtask

  task automatic test_output_hold_off();
    hold_off = 80;
    run_transfer(OP_WRITE, 8'($urandom), 8'($urandom), SDA_RANDOM, 1'b0);
  endtask

  task automatic test_random_ticks();
    for (int n = 0; n < RANDOM_TICKS; n++) begin
      calm = (n >= RANDOM_TICKS - CALM_TICKS);
      if (!calm && $urandom_range(0, 149) == 0) begin
        drain_pipeline();
        if ($urandom_range(0, 1) == 0)
          write_cfg(CFG_DEVICE_ADDRESS, ($urandom_range(0, 3) == 0) ? 8'h7F : 8'($urandom));
        else
          write_cfg(CFG_READ_START_REGISTER,
                    ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
      end
      if (bus_phase == BUS_IDLE && $urandom_range(0, 2) != 0)
        run_transfer_start(1'($urandom));
      else
        bus_tick($urandom_range(0, 9) == 0, SDA_RANDOM);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_DEVICE_ADDRESS;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd_valid  <= 1'b0;
    in_ch.operation  <= OP_WRITE;
    in_ch.reg_addr   <= '0;
    in_ch.write_data <= '0;
    in_ch.sda_in     <= 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bus();
    test_write_extremes();
    test_read_extremes();
    test_cmd_while_busy();
    test_output_hold_off();
    test_cfg_settings();
    test_cfg_mid_transfer();
    test_random_ticks();

    drain_pipeline();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
